// ===== design/ffba_pkg.sv =====
package ffba_pkg;

   // field widths of the request and response beats
   localparam int OP_W     = 2;
   localparam int ADDR_W   = 12;
   localparam int SIZE_W   = 12;
   localparam int STATUS_W = 3;

   localparam int REQ_TDATA_W = 32;
   localparam int RSP_TDATA_W = 16;

   localparam logic [OP_W-1:0] OP_ALLOC  = 2'd0;
   localparam logic [OP_W-1:0] OP_EXTEND = 2'd1;
   localparam logic [OP_W-1:0] OP_FREE   = 2'd2;

   localparam logic [STATUS_W-1:0] STS_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] STS_NO_RUN    = 3'd1;
   localparam logic [STATUS_W-1:0] STS_BAD_SIZE  = 3'd2;
   localparam logic [STATUS_W-1:0] STS_BAD_START = 3'd3;
   localparam logic [STATUS_W-1:0] STS_BLOCKED   = 3'd4;
   localparam logic [STATUS_W-1:0] STS_RANGE     = 3'd5;

   localparam logic [ADDR_W-1:0] NULL_ADDR = '1;

   typedef enum logic [6:0] {
      FSM_CLEAR  = 7'b0000001,
      FSM_IDLE   = 7'b0000010,
      FSM_DECODE = 7'b0000100,
      FSM_SZRD   = 7'b0001000,
      FSM_SCAN   = 7'b0010000,
      FSM_MARK   = 7'b0100000,
      FSM_DONE   = 7'b1000000
   } state_type;

endpackage

// ===== design/ffba_ram.sv =====
module ffba_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/first_fit_block_allocator_core.sv =====
// channel | ports       | beat contents
// --------+-------------+------------------------------------------------------
// request | req_t*      | opcode, block_address, request_size
// result  | rsp_t*      | address_out, status
//
// one request at a time; a new request is taken while the previous result waits.
// allocate: scans the flag store from word 0 for the first free run, then marks the words of the run.
// extend: reads the block size, checks the words after the block, then marks them; stops early when blocked.
// free: reads the block size, then clears each word of the block; errors skip the walk, some after the size read.
// after reset both stores are cleared one word a cycle, with no beats taken.
// each store has one write port and one registered read port.
module first_fit_block_allocator_core #(
   parameter int MEM_WORDS = 2048
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [1:0] opcode, [13:2] block_address, [25:14] request_size
   input  logic [ffba_pkg::REQ_TDATA_W-1:0]   req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [11:0] address_out, [14:12] status
   output logic [ffba_pkg::RSP_TDATA_W-1:0]   rsp_tdata
);

   localparam int AW = $clog2(MEM_WORDS);
   localparam int CW = AW + 1;
   localparam int SW = $clog2(MEM_WORDS + 1);
   localparam int EW = ((CW > ffba_pkg::SIZE_W) ? CW : ffba_pkg::SIZE_W) + 2;
   localparam int AD = ffba_pkg::ADDR_W;

   ffba_pkg::state_type state_ff, state_in;

   logic [ffba_pkg::OP_W-1:0]     op_ff, op_in;
   logic [AD-1:0]                 addr_ff, addr_in;
   logic [ffba_pkg::SIZE_W-1:0]   size_ff, size_in;
   logic [CW-1:0]                 scan_ptr_ff, scan_ptr_in;
   logic [CW-1:0]                 scan_end_ff, scan_end_in;
   logic [CW-1:0]                 chk_ptr_ff, chk_ptr_in;
   logic                          chk_vld_ff, chk_vld_in;
   logic [CW-1:0]                 run_ff, run_in;
   logic [CW-1:0]                 mark_ptr_ff, mark_ptr_in;
   logic [CW-1:0]                 mark_last_ff, mark_last_in;
   logic                          mark_val_ff, mark_val_in;
   logic [AW-1:0]                 szw_addr_ff, szw_addr_in;
   logic [SW-1:0]                 szw_data_ff, szw_data_in;
   logic [AD-1:0]                 res_addr_ff, res_addr_in;
   logic [ffba_pkg::STATUS_W-1:0] res_status_ff, res_status_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [AD-1:0]                 rsp_addr_ff, rsp_addr_in;
   logic [ffba_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;

   logic          flag_we, flag_wdata, flag_rdata;
   logic [AW-1:0] flag_waddr, flag_raddr;
   logic          size_we;
   logic [AW-1:0] size_waddr, size_raddr;
   logic [SW-1:0] size_wdata, size_rdata;

   logic [EW-1:0] addr_ext, size_ext, bs_ext, next_ext, end_ext, start_ext, mem_ext;
   logic          addr_null, addr_bad, issue;
   logic [CW-1:0] run_nxt;

   ffba_ram #(.WIDTH(1), .DEPTH(MEM_WORDS)) u_flag_ram (
      .clock   (clock),
      .wr_en   (flag_we),
      .wr_addr (flag_waddr),
      .wr_data (flag_wdata),
      .rd_addr (flag_raddr),
      .rd_data (flag_rdata)
   );

   ffba_ram #(.WIDTH(SW), .DEPTH(MEM_WORDS)) u_size_ram (
      .clock   (clock),
      .wr_en   (size_we),
      .wr_addr (size_waddr),
      .wr_data (size_wdata),
      .rd_addr (size_raddr),
      .rd_data (size_rdata)
   );

   assign mem_ext   = EW'(MEM_WORDS);
   assign addr_ext  = EW'(addr_ff[AD-2:0]);
   assign addr_null = (addr_ff == ffba_pkg::NULL_ADDR);
   assign addr_bad  = addr_ff[AD-1] || (addr_ext >= mem_ext);
   assign size_ext  = EW'(size_ff);
   assign bs_ext    = EW'(size_rdata);
   assign next_ext  = addr_ext + bs_ext;
   assign end_ext   = next_ext + size_ext;
   assign start_ext = EW'(chk_ptr_ff) + EW'(1) - size_ext;
   assign run_nxt   = run_ff + CW'(1);
   assign issue     = (scan_ptr_ff <= scan_end_ff);

   assign flag_raddr = scan_ptr_ff[AW-1:0];
   assign size_raddr = addr_ext[AW-1:0];

   // store write ports: clearing pass after reset, block marking otherwise
   always_comb begin
      flag_we    = (state_ff == ffba_pkg::FSM_CLEAR) || (state_ff == ffba_pkg::FSM_MARK);
      size_we    = flag_we;
      flag_waddr = mark_ptr_ff[AW-1:0];
      if (state_ff == ffba_pkg::FSM_CLEAR) begin
         flag_wdata = 1'b0;
         size_waddr = mark_ptr_ff[AW-1:0];
         size_wdata = '0;
      end else begin
         flag_wdata = mark_val_ff;
         size_waddr = szw_addr_ff;
         size_wdata = szw_data_ff;
      end
   end

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      addr_in       = addr_ff;
      size_in       = size_ff;
      scan_ptr_in   = scan_ptr_ff;
      scan_end_in   = scan_end_ff;
      chk_ptr_in    = chk_ptr_ff;
      chk_vld_in    = 1'b0;
      run_in        = run_ff;
      mark_ptr_in   = mark_ptr_ff;
      mark_last_in  = mark_last_ff;
      mark_val_in   = mark_val_ff;
      szw_addr_in   = szw_addr_ff;
      szw_data_in   = szw_data_ff;
      res_addr_in   = res_addr_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_addr_in   = rsp_addr_ff;
      rsp_status_in = rsp_status_ff;

      unique case (state_ff)
         ffba_pkg::FSM_CLEAR: begin
            if (mark_ptr_ff == CW'(MEM_WORDS - 1)) begin
               state_in = ffba_pkg::FSM_IDLE;
            end else begin
               mark_ptr_in = mark_ptr_ff + CW'(1);
            end
         end

         ffba_pkg::FSM_IDLE: begin
            if (req_tvalid) begin
               op_in    = req_tdata[1:0];
               addr_in  = req_tdata[13:2];
               size_in  = req_tdata[25:14];
               state_in = ffba_pkg::FSM_DECODE;
            end
         end

         ffba_pkg::FSM_DECODE: begin
            res_addr_in = ffba_pkg::NULL_ADDR;
            state_in    = ffba_pkg::FSM_DONE;
            unique case (op_ff)
               ffba_pkg::OP_ALLOC: begin
                  if (size_ff == '0) begin
                     res_status_in = ffba_pkg::STS_BAD_SIZE;
                  end else if (size_ext > mem_ext) begin
                     res_status_in = ffba_pkg::STS_RANGE;
                  end else begin
                     scan_ptr_in = '0;
                     scan_end_in = CW'(MEM_WORDS - 1);
                     run_in      = '0;
                     state_in    = ffba_pkg::FSM_SCAN;
                  end
               end
               ffba_pkg::OP_EXTEND: begin
                  if (addr_bad) begin
                     res_status_in = ffba_pkg::STS_RANGE;
                  end else if (size_ff == '0) begin
                     res_status_in = ffba_pkg::STS_BAD_SIZE;
                  end else begin
                     state_in = ffba_pkg::FSM_SZRD;
                  end
               end
               ffba_pkg::OP_FREE: begin
                  if (addr_null) begin
                     res_status_in = ffba_pkg::STS_OK;
                  end else if (addr_bad) begin
                     res_status_in = ffba_pkg::STS_RANGE;
                  end else begin
                     state_in = ffba_pkg::FSM_SZRD;
                  end
               end
               default: begin
                  res_status_in = ffba_pkg::STS_RANGE;
               end
            endcase
         end

         // block size of addr_ff is on the read port now
         ffba_pkg::FSM_SZRD: begin
            szw_addr_in = addr_ext[AW-1:0];
            if (size_rdata == '0) begin
               res_addr_in   = ffba_pkg::NULL_ADDR;
               res_status_in = ffba_pkg::STS_BAD_START;
               state_in      = ffba_pkg::FSM_DONE;
            end else if (op_ff == ffba_pkg::OP_FREE) begin
               mark_ptr_in   = addr_ext[CW-1:0];
               mark_last_in  = CW'(next_ext - EW'(1));
               mark_val_in   = 1'b0;
               szw_data_in   = '0;
               res_addr_in   = addr_ff;
               res_status_in = ffba_pkg::STS_OK;
               state_in      = ffba_pkg::FSM_MARK;
            end else if (end_ext > mem_ext) begin
               res_addr_in   = ffba_pkg::NULL_ADDR;
               res_status_in = ffba_pkg::STS_RANGE;
               state_in      = ffba_pkg::FSM_DONE;
            end else begin
               scan_ptr_in  = CW'(next_ext);
               scan_end_in  = CW'(end_ext - EW'(1));
               mark_ptr_in  = CW'(next_ext);
               mark_last_in = CW'(end_ext - EW'(1));
               mark_val_in  = 1'b1;
               szw_data_in  = SW'(bs_ext + size_ext);
               state_in     = ffba_pkg::FSM_SCAN;
            end
         end

         // reads issued one word a cycle; flag_rdata is the registered flag of chk_ptr_ff
         ffba_pkg::FSM_SCAN: begin
            if (issue) begin
               scan_ptr_in = scan_ptr_ff + CW'(1);
               chk_ptr_in  = scan_ptr_ff;
               chk_vld_in  = 1'b1;
            end
            if (chk_vld_ff) begin
               if (op_ff == ffba_pkg::OP_ALLOC) begin
                  run_in = flag_rdata ? '0 : run_nxt;
                  if (!flag_rdata && (EW'(run_nxt) == size_ext)) begin
                     mark_ptr_in   = CW'(start_ext);
                     mark_last_in  = chk_ptr_ff;
                     mark_val_in   = 1'b1;
                     szw_addr_in   = start_ext[AW-1:0];
                     szw_data_in   = SW'(size_ext);
                     res_addr_in   = start_ext[AD-1:0];
                     res_status_in = ffba_pkg::STS_OK;
                     chk_vld_in    = 1'b0;
                     state_in      = ffba_pkg::FSM_MARK;
                  end else if (chk_ptr_ff == scan_end_ff) begin
                     res_addr_in   = ffba_pkg::NULL_ADDR;
                     res_status_in = ffba_pkg::STS_NO_RUN;
                     chk_vld_in    = 1'b0;
                     state_in      = ffba_pkg::FSM_DONE;
                  end
               end else begin
                  if (flag_rdata) begin
                     res_addr_in   = ffba_pkg::NULL_ADDR;
                     res_status_in = ffba_pkg::STS_BLOCKED;
                     chk_vld_in    = 1'b0;
                     state_in      = ffba_pkg::FSM_DONE;
                  end else if (chk_ptr_ff == scan_end_ff) begin
                     res_addr_in   = addr_ff;
                     res_status_in = ffba_pkg::STS_OK;
                     chk_vld_in    = 1'b0;
                     state_in      = ffba_pkg::FSM_MARK;
                  end
               end
            end
         end

         // size entry is rewritten every cycle of the walk, same value each time
         ffba_pkg::FSM_MARK: begin
            if (mark_ptr_ff == mark_last_ff) begin
               state_in = ffba_pkg::FSM_DONE;
            end else begin
               mark_ptr_in = mark_ptr_ff + CW'(1);
            end
         end

         ffba_pkg::FSM_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_addr_in   = res_addr_ff;
               rsp_status_in = res_status_ff;
               state_in      = ffba_pkg::FSM_IDLE;
            end
         end

         default: begin
            state_in = ffba_pkg::FSM_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ffba_pkg::FSM_CLEAR;
         mark_ptr_ff  <= '0;
         chk_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mark_ptr_ff  <= mark_ptr_in;
         chk_vld_ff   <= chk_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      addr_ff       <= addr_in;
      size_ff       <= size_in;
      scan_ptr_ff   <= scan_ptr_in;
      scan_end_ff   <= scan_end_in;
      chk_ptr_ff    <= chk_ptr_in;
      run_ff        <= run_in;
      mark_last_ff  <= mark_last_in;
      mark_val_ff   <= mark_val_in;
      szw_addr_ff   <= szw_addr_in;
      szw_data_ff   <= szw_data_in;
      res_addr_ff   <= res_addr_in;
      res_status_ff <= res_status_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign req_tready = (state_ff == ffba_pkg::FSM_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_status_ff, rsp_addr_ff};

endmodule
